/* sv/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic timer slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_CREATE  = 2'd1;
  localparam logic [1:0] FUNC_DELETE  = 2'd2;
  localparam logic [1:0] FUNC_SERVICE = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_delay;
    logic [31:0] reload_period;
    logic [3:0]  slot_id;
  } pts_in_t;

  typedef struct packed {
    logic       reply_kind;
    logic [3:0] slot_number;
    logic       last;
  } pts_out_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_delay;
    logic [31:0] reload_period;
    logic [3:0]  slot_id;
    logic        del_ok;
  } pts_cmd_t;

endpackage

`default_nettype wire

/* sv/pts_front.sv */
// ----------------------------------------------------------------------------
// pts_front
// Takes command transfers, checks delete slot numbers and holds commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_front #(
  parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire pts_pkg::pts_in_t in_data,
  output logic                  cmd_valid,
  output pts_pkg::pts_cmd_t     cmd,
  input  wire logic             cmd_pop
);
  import pts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = ($clog2(SLOT_COUNT + 1) > 4) ? $clog2(SLOT_COUNT + 1) : 4;

  pts_cmd_t       q_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QW-1:0]  count_r, count_nxt;
  logic           push;
  logic           pop;
  pts_cmd_t       cls;

  assign busy      = (count_r == QW'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cls.func          = in_data.func;
    cls.start_delay   = in_data.start_delay;
    cls.reload_period = in_data.reload_period;
    cls.slot_id       = in_data.slot_id;
    cls.del_ok        = (in_data.slot_id != 4'd0) &&
                        (DW'(in_data.slot_id) <= DW'(SLOT_COUNT));
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

/* sv/pts_back.sv */
// ----------------------------------------------------------------------------
// pts_back
// Executes queued commands against the slot table: tick count, create,
// delete, and the service walk that visits one slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_back #(
  parameter int SLOT_COUNT  = pts_pkg::SLOT_COUNT_DEF,
  parameter int COUNT_WIDTH = pts_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire pts_pkg::pts_cmd_t cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  output pts_pkg::pts_out_t      out_data
);
  import pts_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NW = IW + 1;
  localparam int WW = $clog2(SLOT_COUNT + 1);
  localparam int CW = COUNT_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SVC   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Slot storage; busy flags double as valid bits for the countdown memory
  logic [CW-1:0]          cd_mem  [SLOT_COUNT];
  logic [CW-1:0]          per_mem [SLOT_COUNT];
  logic [CW-1:0]          cd_rd_r;
  logic [CW-1:0]          per_rd_r;

  logic [1:0]             state_r, state_nxt;
  logic [SLOT_COUNT-1:0]  busy_r, busy_nxt;
  logic [CW-1:0]          pending_r, pending_nxt;
  logic [CW-1:0]          elapsed_r, elapsed_nxt;
  logic [WW-1:0]          walk_r, walk_nxt;
  logic                   proc_vld_r, proc_vld_nxt;
  logic [IW-1:0]          proc_idx_r, proc_idx_nxt;
  logic                   held_vld_r, held_vld_nxt;
  logic [IW-1:0]          held_idx_r, held_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pts_out_t               out_r, out_nxt;

  logic                   cd_we, per_we;
  logic [IW-1:0]          wr_addr;
  logic [IW-1:0]          rd_addr;
  logic [CW-1:0]          cd_wd, per_wd;
  logic [CW-1:0]          cd_cur, cd_new;
  logic                   free_found;
  logic [IW-1:0]          free_idx;
  logic [IW-1:0]          del_idx;

  function automatic logic [3:0] slot_num(input logic [IW-1:0] idx);
    logic [NW-1:0] s;
    s = {1'b0, idx} + NW'(1);
    return 4'(s);
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign del_idx   = IW'(cmd.slot_id - 4'd1);
  assign rd_addr   = (walk_r < WW'(SLOT_COUNT)) ? IW'(walk_r) : '0;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    pending_nxt   = pending_r;
    elapsed_nxt   = elapsed_r;
    walk_nxt      = walk_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    held_vld_nxt  = held_vld_r;
    held_idx_nxt  = held_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    cd_we         = 1'b0;
    per_we        = 1'b0;
    wr_addr       = '0;
    cd_wd         = '0;
    per_wd        = '0;
    cd_cur        = busy_r[proc_idx_r] ? cd_rd_r : '0;
    cd_new        = (cd_cur > elapsed_r) ? cd_cur - elapsed_r : '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.func)
            FUNC_TICK: begin
              if (pending_r != '1) begin
                pending_nxt = pending_r + CW'(1);
              end
            end
            FUNC_CREATE: begin
              out_valid_nxt       = 1'b1;
              out_nxt.reply_kind  = KIND_REPLY;
              out_nxt.slot_number = free_found ? slot_num(free_idx) : 4'd0;
              out_nxt.last        = 1'b1;
              if (free_found) begin
                cd_we              = 1'b1;
                per_we             = 1'b1;
                wr_addr            = free_idx;
                cd_wd              = CW'(cmd.start_delay);
                per_wd             = CW'(cmd.reload_period);
                busy_nxt[free_idx] = 1'b1;
              end
            end
            FUNC_DELETE: begin
              if (cmd.del_ok) begin
                cd_we             = 1'b1;
                per_we            = 1'b1;
                wr_addr           = del_idx;
                busy_nxt[del_idx] = 1'b0;
              end
            end
            FUNC_SERVICE: begin
              elapsed_nxt  = pending_r;
              pending_nxt  = '0;
              walk_nxt     = '0;
              held_vld_nxt = 1'b0;
              state_nxt    = ST_SVC;
            end
            default: ;
          endcase
        end
      end
      ST_SVC: begin
        // Issue the next slot read while the previous slot is processed
        if (walk_r < WW'(SLOT_COUNT)) begin
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = IW'(walk_r);
          walk_nxt     = walk_r + WW'(1);
        end
        if (proc_vld_r) begin
          if (cd_cur != '0) begin
            cd_we   = 1'b1;
            wr_addr = proc_idx_r;
            cd_wd   = cd_new;
            if (cd_new == '0) begin
              // Release the held event; the new one waits to learn if it is last
              if (held_vld_r) begin
                out_valid_nxt       = 1'b1;
                out_nxt.reply_kind  = KIND_EXPIRY;
                out_nxt.slot_number = slot_num(held_idx_r);
                out_nxt.last        = 1'b0;
              end
              held_vld_nxt = 1'b1;
              held_idx_nxt = proc_idx_r;
              if (per_rd_r != '0) begin
                cd_wd = per_rd_r;
              end else begin
                busy_nxt[proc_idx_r] = 1'b0;
              end
            end
          end
          if (proc_idx_r == IW'(SLOT_COUNT - 1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (held_vld_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.reply_kind  = KIND_EXPIRY;
          out_nxt.slot_number = slot_num(held_idx_r);
          out_nxt.last        = 1'b1;
        end
        held_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      pending_r   <= '0;
      walk_r      <= '0;
      proc_vld_r  <= 1'b0;
      held_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      pending_r   <= pending_nxt;
      walk_r      <= walk_nxt;
      proc_vld_r  <= proc_vld_nxt;
      held_vld_r  <= held_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r  <= elapsed_nxt;
    proc_idx_r <= proc_idx_nxt;
    held_idx_r <= held_idx_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[wr_addr] <= cd_wd;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_wd;
    end
    cd_rd_r  <= cd_mem[rd_addr];
    per_rd_r <= per_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/periodic_timer_slot_table.sv */
// A command enters a two-entry queue and is popped by the back end while it is idle;
// tick and delete then update the state directly, and a create reply is registered.
// Service walks the slot memory one slot per cycle, with expiry events one per
// cycle at most; busy is high only while the queue is full.
// Reset clears the queue, the busy flags and the tick count; no clearing pass.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// periodic_timer_slot_table
// Table of one-shot and periodic timer slots driven by tick, create, delete
// and service commands.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_slot_table #(
  parameter int SLOT_COUNT  = pts_pkg::SLOT_COUNT_DEF,
  parameter int COUNT_WIDTH = pts_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire pts_pkg::pts_in_t in_data,
  output logic                  out_valid,
  output pts_pkg::pts_out_t     out_data
);
  import pts_pkg::*;

  logic     cmd_valid;
  logic     cmd_pop;
  pts_cmd_t cmd;

  pts_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pts_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sv/pts_checker.sv */
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire pts_pkg::pts_out_t out_data
);
  import pts_pkg::*;

  // Reset clears the queue and the result strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy after reset");

  // A create reply is always the only result of its command
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_kind == KIND_REPLY |-> out_data.last)
    else $error("create reply not marked last");

  // Expiry events always name a real slot
  a_expiry_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_kind == KIND_EXPIRY |-> out_data.slot_number != 4'd0)
    else $error("expiry event with slot 0");

  // A non-final expiry is followed by more events of the same walk, never a reply
  a_no_reply_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_kind == KIND_EXPIRY && !out_data.last |=>
      !(out_valid && out_data.reply_kind == KIND_REPLY))
    else $error("create reply inside an expiry burst");

endmodule

bind periodic_timer_slot_table pts_checker u_pts_checker (.*);

`default_nettype wire
